// ===== design/psfb_pkg.sv =====
package psfb_pkg;

  // Fixed geometry of the bank
  localparam int ChW    = 3;   // channel index width (8 channels)
  localparam int SlotW  = 5;   // history ring slot index width (17 slots)
  localparam int InnerW = 5;   // inner loop counter width
  localparam int AddrW  = SlotW + ChW;
  localparam int MemDepth = 136;
  localparam int CoefW  = 24;  // Q1.23
  localparam int OpW    = 40;  // widest multiplier operand
  localparam int AccW   = 64;

  localparam logic [SlotW-1:0]  LAST_SLOT = 5'd16;
  localparam logic [ChW-1:0]    LAST_CH   = 3'd7;
  localparam logic [InnerW-1:0] LAST_TAP  = 5'd16;
  localparam logic [InnerW-1:0] LAST_FWD  = 5'd7;
  localparam logic [InnerW-1:0] LAST_INV  = 5'd15;

  // Twiddle magnitudes in Q1.23: unity (clamped) and cos(pi/4)
  localparam logic signed [CoefW-1:0] TW_ONE  = 24'sd8388607;
  localparam logic signed [CoefW-1:0] TW_DIAG = 24'sd5931642;

  // Prototype quantization helpers
  localparam longint Q23 = 64'sd8388608;
  localparam longint X1  = 64'sd10000000;
  localparam longint X2  = 64'sd100000000;
  localparam longint X3  = 64'sd1000000000;
  localparam longint X4  = 64'sd10000000000;
  localparam longint X6  = 64'sd1000000000000;

  // First half of the symmetric 129-tap prototype, Q1.23, rounded half away from zero
  localparam logic signed [CoefW-1:0] PROTO_HALF [65] = '{
    24'((-6315349 * Q23 - X4 / 2) / X4), 24'((-5510414 * Q23 - X4 / 2) / X4),
    24'((-3259621 * Q23 - X4 / 2) / X4), 24'((2340440 * Q23 + X6 / 2) / X6),
    24'((3642858 * Q23 + X4 / 2) / X4),  24'((6766050 * Q23 + X4 / 2) / X4),
    24'((8611797 * Q23 + X4 / 2) / X4),  24'((8640147 * Q23 + X4 / 2) / X4),
    24'((6698439 * Q23 + X4 / 2) / X4),  24'((3085988 * Q23 + X4 / 2) / X4),
    24'((-1483775 * Q23 - X4 / 2) / X4), 24'((-6022076 * Q23 - X4 / 2) / X4),
    24'((-9478917 * Q23 - X4 / 2) / X4), 24'((-1098731 * Q23 - X3 / 2) / X3),
    24'((-1008196 * Q23 - X3 / 2) / X3), 24'((-6838552 * Q23 - X4 / 2) / X4),
    24'((-1894605 * Q23 - X4 / 2) / X4), 24'((3662389 * Q23 + X4 / 2) / X4),
    24'((8523396 * Q23 + X4 / 2) / X4),  24'((1145797 * Q23 + X3 / 2) / X3),
    24'((1162045 * Q23 + X3 / 2) / X3),  24'((8789646 * Q23 + X4 / 2) / X4),
    24'((3478767 * Q23 + X4 / 2) / X4),  24'((-3122778 * Q23 - X4 / 2) / X4),
    24'((-9377814 * Q23 - X4 / 2) / X4), 24'((-1356247 * Q23 - X3 / 2) / X3),
    24'((-1428731 * Q23 - X3 / 2) / X3), 24'((-1088462 * Q23 - X3 / 2) / X3),
    24'((-3666099 * Q23 - X4 / 2) / X4), 24'((6024938 * Q23 + X4 / 2) / X4),
    24'((1600312 * Q23 + X3 / 2) / X3),  24'((2365728 * Q23 + X3 / 2) / X3),
    24'((2652446 * Q23 + X3 / 2) / X3),  24'((2290888 * Q23 + X3 / 2) / X3),
    24'((1240943 * Q23 + X3 / 2) / X3),  24'((-3776170 * Q23 - X4 / 2) / X4),
    24'((-2286936 * Q23 - X3 / 2) / X3), 24'((-4089015 * Q23 - X3 / 2) / X3),
    24'((-5336370 * Q23 - X3 / 2) / X3), 24'((-5624458 * Q23 - X3 / 2) / X3),
    24'((-4688907 * Q23 - X3 / 2) / X3), 24'((-2487475 * Q23 - X3 / 2) / X3),
    24'((7526787 * Q23 + X4 / 2) / X4),  24'((4537047 * Q23 + X3 / 2) / X3),
    24'((8161600 * Q23 + X3 / 2) / X3),  24'((1082239 * Q23 + X2 / 2) / X2),
    24'((1176229 * Q23 + X2 / 2) / X2),  24'((1043122 * Q23 + X2 / 2) / X2),
    24'((6631116 * Q23 + X3 / 2) / X3),  24'((6163657 * Q23 + X4 / 2) / X4),
    24'((-6874063 * Q23 - X3 / 2) / X3), 24'((-1466670 * Q23 - X2 / 2) / X2),
    24'((-2128611 * Q23 - X2 / 2) / X2), 24'((-2515561 * Q23 - X2 / 2) / X2),
    24'((-2483840 * Q23 - X2 / 2) / X2), 24'((-1928255 * Q23 - X2 / 2) / X2),
    24'((-8029233 * Q23 - X3 / 2) / X3), 24'((8652438 * Q23 + X3 / 2) / X3),
    24'((2973120 * Q23 + X2 / 2) / X2),  24'((5349194 * Q23 + X2 / 2) / X2),
    24'((7772069 * Q23 + X2 / 2) / X2),  24'((9997327 * Q23 + X2 / 2) / X2),
    24'((1178896 * Q23 + X1 / 2) / X1),  24'((1295080 * Q23 + X1 / 2) / X1),
    24'((1335319 * Q23 + X1 / 2) / X1)
  };

  // Dot-product kinds run by the shared MAC
  typedef enum logic [2:0] {
    MODE_ANA,  // analysis branch filter
    MODE_FRE,  // forward DFT, real part
    MODE_FIM,  // forward DFT, imaginary part
    MODE_INV,  // inverse DFT
    MODE_SYN   // synthesis branch filter
  } mode_e;

  // One MAC step issued by the controller
  typedef struct packed {
    logic              vld;
    mode_e             mode;
    logic [ChW-1:0]    outer;
    logic [InnerW-1:0] inner;
    logic              first;
    logic              last;
  } step_t;

  typedef struct packed {
    logic  take;        // input transaction this cycle
    step_t step;
    logic  adv_head;    // block done, move ring head
    logic  emit_start;  // start output burst
  } cmd_t;

  typedef struct packed {
    logic cnt_full;     // staging holds seven samples
    logic emit_busy;
    logic result_done;  // dot product written back
  } st_t;

  // Zero-padded prototype tap at index idx
  function automatic logic signed [CoefW-1:0] coef_at(input logic [AddrW-1:0] idx);
    logic [6:0] h;
    h = '0;
    if (idx > 8'd128) begin
      return '0;
    end else begin
      h = (idx <= 8'd64) ? idx[6:0] : 7'(8'd128 - idx);
      return PROTO_HALF[h];
    end
  endfunction

  function automatic logic signed [CoefW-1:0] tw_cos(input logic [ChW-1:0] j);
    logic signed [CoefW-1:0] r;
    case (j)
      3'd0:    r = TW_ONE;
      3'd1:    r = TW_DIAG;
      3'd2:    r = '0;
      3'd3:    r = -TW_DIAG;
      3'd4:    r = -TW_ONE;
      3'd5:    r = -TW_DIAG;
      3'd6:    r = '0;
      default: r = TW_DIAG;
    endcase
    return r;
  endfunction

  function automatic logic signed [CoefW-1:0] tw_sin(input logic [ChW-1:0] j);
    logic signed [CoefW-1:0] r;
    case (j)
      3'd0:    r = '0;
      3'd1:    r = TW_DIAG;
      3'd2:    r = TW_ONE;
      3'd3:    r = TW_DIAG;
      3'd4:    r = '0;
      3'd5:    r = -TW_DIAG;
      3'd6:    r = -TW_ONE;
      default: r = -TW_DIAG;
    endcase
    return r;
  endfunction

  // Divide by 2^sh, round half away from zero, saturate to a bits-wide signed field
  function automatic logic signed [AccW-1:0] rnd_sat(input logic signed [AccW-1:0] acc,
                                                     input int sh, input int bits);
    logic            neg;
    logic [AccW-1:0] mag;
    logic [AccW-1:0] q;
    logic [AccW-1:0] lim;
    neg = acc[AccW-1];
    mag = neg ? AccW'(-acc) : AccW'(acc);
    q   = mag >> sh;
    if (mag[sh-1]) q = q + 64'd1;
    lim = (64'd1 << (bits - 1)) - (neg ? 64'd0 : 64'd1);
    if (q > lim) q = lim;
    return neg ? -$signed(q) : $signed(q);
  endfunction

endpackage

// ===== design/psfb_ctrl.sv =====
module psfb_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  input  logic            s_req_i,
  output logic            s_ready_o,
  input  psfb_pkg::st_t   st_i,
  output psfb_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_WAIT = 3'b100
  } state_e;

  state_e                         state_q, state_d;
  psfb_pkg::mode_e                mode_q, mode_d;
  logic [psfb_pkg::ChW-1:0]       o_q, o_d;
  logic [psfb_pkg::InnerW-1:0]    i_q, i_d;
  logic [psfb_pkg::InnerW-1:0]    last_idx;
  logic                           take;
  logic                           blk_done;

  // Run length per dot-product kind
  always_comb begin
    unique case (mode_q)
      psfb_pkg::MODE_FRE, psfb_pkg::MODE_FIM: last_idx = psfb_pkg::LAST_FWD;
      psfb_pkg::MODE_INV:                     last_idx = psfb_pkg::LAST_INV;
      default:                                last_idx = psfb_pkg::LAST_TAP;
    endcase
  end

  // The block-completing sample waits while the output buffer drains
  assign s_ready_o = (state_q == S_IDLE) &&
                     !(st_i.emit_busy && st_i.cnt_full && !s_req_i);
  assign take      = s_valid_i && s_ready_o;
  assign blk_done  = (state_q == S_WAIT) && st_i.result_done &&
                     (mode_q == psfb_pkg::MODE_SYN) && (o_q == psfb_pkg::LAST_CH);

  always_comb begin
    cmd_o            = '0;
    cmd_o.take       = take;
    cmd_o.step.vld   = (state_q == S_RUN);
    cmd_o.step.mode  = mode_q;
    cmd_o.step.outer = o_q;
    cmd_o.step.inner = i_q;
    cmd_o.step.first = (i_q == '0);
    cmd_o.step.last  = (i_q == last_idx);
    cmd_o.adv_head   = blk_done;
    cmd_o.emit_start = blk_done;
  end

  // Sequencer: analysis, forward DFT, then inverse/synthesis per branch
  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    o_d     = o_q;
    i_d     = i_q;
    unique case (state_q)
      S_IDLE: begin
        if (take && !s_req_i && st_i.cnt_full) begin
          state_d = S_RUN;
          mode_d  = psfb_pkg::MODE_ANA;
          o_d     = '0;
          i_d     = '0;
        end
      end
      S_RUN: begin
        if (i_q == last_idx) begin
          state_d = S_WAIT;
          i_d     = '0;
        end else begin
          i_d = i_q + 5'd1;
        end
      end
      S_WAIT: begin
        if (st_i.result_done) begin
          state_d = S_RUN;
          unique case (mode_q)
            psfb_pkg::MODE_ANA: begin
              if (o_q == psfb_pkg::LAST_CH) begin
                mode_d = psfb_pkg::MODE_FRE;
                o_d    = '0;
              end else begin
                o_d = o_q + 3'd1;
              end
            end
            psfb_pkg::MODE_FRE: mode_d = psfb_pkg::MODE_FIM;
            psfb_pkg::MODE_FIM: begin
              if (o_q == psfb_pkg::LAST_CH) begin
                mode_d = psfb_pkg::MODE_INV;
                o_d    = '0;
              end else begin
                mode_d = psfb_pkg::MODE_FRE;
                o_d    = o_q + 3'd1;
              end
            end
            psfb_pkg::MODE_INV: mode_d = psfb_pkg::MODE_SYN;
            default: begin
              if (o_q == psfb_pkg::LAST_CH) begin
                state_d = S_IDLE;
              end else begin
                mode_d = psfb_pkg::MODE_INV;
                o_d    = o_q + 3'd1;
              end
            end
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= psfb_pkg::MODE_ANA;
      o_q     <= '0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      o_q     <= o_d;
      i_q     <= i_d;
    end
  end

endmodule

// ===== design/psfb_datapath.sv =====
module psfb_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psfb_pkg::cmd_t      cmd_i,
  output psfb_pkg::st_t       st_o,
  input  logic                in_req_i,
  input  logic signed [15:0]  in_sample_i,
  input  logic                in_last_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [15:0]  out_sample_o,
  output logic                out_last_o
);

  localparam int SlotW = psfb_pkg::SlotW;
  localparam int ChW   = psfb_pkg::ChW;
  localparam int AddrW = psfb_pkg::AddrW;
  localparam int OpW   = psfb_pkg::OpW;
  localparam int CoefW = psfb_pkg::CoefW;
  localparam int AccW  = psfb_pkg::AccW;

  // Staging count, ring head and per-slot valid bits
  logic [ChW-1:0]          cnt_q;
  logic [SlotW-1:0]        fill_q;
  logic [16:0]             row_vld_q;

  // History memories, addressed {slot, branch}
  logic signed [15:0]      ana_mem [psfb_pkg::MemDepth];
  logic signed [31:0]      syn_mem [psfb_pkg::MemDepth];

  // Intermediate results
  logic signed [31:0]      branch_q [8];
  logic signed [OpW-1:0]   re_q [8];
  logic signed [OpW-1:0]   im_q [8];
  logic signed [15:0]      obuf_q [8];

  // Pipeline
  psfb_pkg::step_t         step;
  logic [5:0]              diff;
  logic [SlotW-1:0]        rd_slot;
  logic [AddrW-1:0]        rd_addr;
  logic [5:0]              fwd_prod;
  logic [5:0]              inv_prod;
  logic signed [OpW-1:0]   regop;
  logic signed [CoefW-1:0] bop;

  logic                    vld1_q, vld2_q, done3_q, rdone_q;
  psfb_pkg::mode_e         mode1_q, mode2_q, mode3_q;
  logic [ChW-1:0]          outer1_q, outer2_q, outer3_q;
  logic                    first1_q, last1_q, first2_q, last2_q;
  logic signed [15:0]      a_rd_q;
  logic signed [31:0]      s_rd_q;
  logic                    ok1_q;
  logic signed [OpW-1:0]   regop1_q;
  logic signed [CoefW-1:0] b1_q;
  logic signed [OpW-1:0]   opa;
  logic signed [AccW-1:0]  prod2_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [AccW-1:0]  scaled;
  logic                    syn_we;
  logic [AddrW-1:0]        syn_waddr;
  logic signed [31:0]      syn_wdata;

  logic                    emit_busy_q;
  logic [ChW-1:0]          eidx_q;

  assign step = cmd_i.step;

  // Staging count, ring head and slot valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      fill_q    <= '0;
      row_vld_q <= '0;
    end else begin
      if (cmd_i.take) begin
        if (in_req_i) begin
          cnt_q     <= '0;
          row_vld_q <= '0;
        end else if (cnt_q == psfb_pkg::LAST_CH) begin
          cnt_q             <= '0;
          row_vld_q[fill_q] <= 1'b1;
        end else begin
          cnt_q <= in_last_i ? '0 : cnt_q + 3'd1;
        end
      end
      if (cmd_i.adv_head) begin
        fill_q <= (fill_q == psfb_pkg::LAST_SLOT) ? '0 : fill_q + 5'd1;
      end
    end
  end

  // Samples land newest-first in the slot being filled
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && !in_req_i) begin
      ana_mem[{fill_q, ~cnt_q}] <= in_sample_i;
    end
    a_rd_q <= ana_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (syn_we) begin
      syn_mem[syn_waddr] <= syn_wdata;
    end
    s_rd_q <= syn_mem[rd_addr];
  end

  // Tap m of a branch sits m slots behind the head, modulo 17
  always_comb begin
    diff     = {1'b0, fill_q} - {1'b0, step.inner};
    rd_slot  = diff[5] ? SlotW'(diff + 6'd17) : diff[SlotW-1:0];
    rd_addr  = {rd_slot, step.outer};
    fwd_prod = step.outer * step.inner[2:0];
    inv_prod = step.outer * step.inner[3:1];
  end

  // Operand select for the non-memory operand and the coefficient/twiddle
  always_comb begin
    regop = '0;
    bop   = '0;
    unique case (step.mode)
      psfb_pkg::MODE_FRE: begin
        regop = {{8{branch_q[step.inner[2:0]][31]}}, branch_q[step.inner[2:0]]};
        bop   = psfb_pkg::tw_cos(fwd_prod[2:0]);
      end
      psfb_pkg::MODE_FIM: begin
        regop = {{8{branch_q[step.inner[2:0]][31]}}, branch_q[step.inner[2:0]]};
        bop   = psfb_pkg::tw_sin(fwd_prod[2:0]);
      end
      psfb_pkg::MODE_INV: begin
        regop = step.inner[0] ? im_q[step.inner[3:1]] : re_q[step.inner[3:1]];
        bop   = step.inner[0] ? psfb_pkg::tw_sin(inv_prod[2:0])
                              : psfb_pkg::tw_cos(inv_prod[2:0]);
      end
      default: begin
        bop = psfb_pkg::coef_at({step.inner[3:0], step.outer} |
                                (step.inner[4] ? 8'd128 : 8'd0));
      end
    endcase
  end

  // Stage 1: operands registered
  always_ff @(posedge clk_i) begin
    regop1_q <= regop;
    b1_q     <= bop;
    ok1_q    <= row_vld_q[rd_slot];
    mode1_q  <= step.mode;
    outer1_q <= step.outer;
    first1_q <= step.first;
    last1_q  <= step.last;
  end

  // Stage 2: multiply; slots never written since clear read as zero
  always_comb begin
    unique case (mode1_q)
      psfb_pkg::MODE_ANA: opa = ok1_q ? {{24{a_rd_q[15]}}, a_rd_q} : '0;
      psfb_pkg::MODE_SYN: opa = ok1_q ? {{8{s_rd_q[31]}}, s_rd_q} : '0;
      default:            opa = regop1_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod2_q  <= AccW'(opa) * AccW'(b1_q);
    mode2_q  <= mode1_q;
    outer2_q <= outer1_q;
    first2_q <= first1_q;
    last2_q  <= last1_q;
  end

  // Stage 3: accumulate
  always_ff @(posedge clk_i) begin
    if (vld2_q) begin
      acc_q <= first2_q ? prod2_q : acc_q + prod2_q;
    end
    mode3_q  <= mode2_q;
    outer3_q <= outer2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q  <= 1'b0;
      vld2_q  <= 1'b0;
      done3_q <= 1'b0;
      rdone_q <= 1'b0;
    end else begin
      vld1_q  <= step.vld;
      vld2_q  <= vld1_q;
      done3_q <= vld2_q && last2_q;
      rdone_q <= done3_q;
    end
  end

  // Stage 4: round, saturate and write back
  assign scaled    = {acc_q[AccW-4:0], 3'b000};
  assign syn_we    = done3_q && (mode3_q == psfb_pkg::MODE_INV);
  assign syn_waddr = {fill_q, outer3_q};
  assign syn_wdata = 32'(psfb_pkg::rnd_sat(acc_q, 26, 32));

  always_ff @(posedge clk_i) begin
    if (done3_q) begin
      unique case (mode3_q)
        psfb_pkg::MODE_ANA: branch_q[outer3_q] <= 32'(psfb_pkg::rnd_sat(acc_q, 15, 32));
        psfb_pkg::MODE_FRE: re_q[outer3_q] <= 40'(psfb_pkg::rnd_sat(acc_q, 23, 40));
        psfb_pkg::MODE_FIM: im_q[outer3_q] <= 40'(psfb_pkg::rnd_sat(acc_q, 23, 40));
        psfb_pkg::MODE_SYN: obuf_q[outer3_q] <= 16'(psfb_pkg::rnd_sat(scaled, 31, 16));
        default: ;
      endcase
    end
  end

  // Output burst: branches in reverse order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_busy_q <= 1'b0;
      eidx_q      <= '0;
    end else if (cmd_i.emit_start) begin
      emit_busy_q <= 1'b1;
      eidx_q      <= psfb_pkg::LAST_CH;
    end else if (emit_busy_q && out_ready_i) begin
      if (eidx_q == '0) begin
        emit_busy_q <= 1'b0;
      end else begin
        eidx_q <= eidx_q - 3'd1;
      end
    end
  end

  assign out_valid_o  = emit_busy_q;
  assign out_sample_o = obuf_q[eidx_q];
  assign out_last_o   = (eidx_q == '0);

  assign st_o.cnt_full    = (cnt_q == psfb_pkg::LAST_CH);
  assign st_o.emit_busy   = emit_busy_q;
  assign st_o.result_done = rdone_q;

endmodule

// ===== design/polyphase_subband_filter_bank.sv =====
// Eight-channel polyphase analysis/synthesis filter bank on signed 16-bit
// samples. Input transactions carry a sample (tuser = 0) or a clear request
// (tuser = 1); samples are taken one per cycle while the block is idle (a
// block-completing sample also waits while the output burst drains), and
// every eighth sample starts a block that yields eight output transactions,
// tlast on the eighth. tlast on an input ends the frame and drops a partial
// block. All filtering, both DFTs and the synthesis run on one shared MAC
// pipeline (528 multiply-accumulates in 40 dot products, with a pipeline
// turnaround after each). Histories live in two 136-entry ring memories with
// per-slot valid bits; reset and clear take effect at once, no clearing pass.
module polyphase_subband_filter_bank (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  input  logic        s_axis_tuser,   // [0] req_type
  input  logic        s_axis_tlast,   // frame_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] out_sample
  output logic        m_axis_tlast    // last_of_block
);

  psfb_pkg::cmd_t     cmd;
  psfb_pkg::st_t      st;
  logic signed [15:0] out_sample;

  psfb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_req_i   (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  psfb_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .st_o         (st),
    .in_req_i     (s_axis_tuser),
    .in_sample_i  ($signed(s_axis_tdata)),
    .in_last_i    (s_axis_tlast),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_sample_o (out_sample),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = out_sample;

endmodule

// ===== design/psfb_checker.sv =====
module psfb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // No output while reset is held
  a_rst_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

  // A stalled output transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output changed");

  // A burst ends with its last transaction
  a_burst_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
    else $error("output continued past end of block");

  // A burst opens on a non-last item, after the input side was held off
  a_burst_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !m_axis_tlast && $past(!s_axis_tready))
    else $error("bad start of output burst");

endmodule

bind polyphase_subband_filter_bank psfb_checker u_psfb_checker (.*);
